/* hw/rtl/dqs_pkg.sv */
package dqs_pkg;

    // Field widths of the request and result channels.
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    // Default number of cells in the chain.
    localparam int DEPTH_DEF = 64;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_MARK       = 3'd5,
        OP_ROTATE     = 3'd6
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

/* hw/rtl/dqs_cell.sv */
module dqs_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dqs_pkg::cell_ctrl_t               ctrl,
    input  logic signed [dqs_pkg::DATA_W-1:0] left_data,
    input  logic                              left_valid,
    input  logic signed [dqs_pkg::DATA_W-1:0] right_data,
    input  logic                              right_valid,
    input  logic                              right_tag,
    input  logic signed [dqs_pkg::DATA_W-1:0] head_data,
    input  logic                              head_tag,
    output logic signed [dqs_pkg::DATA_W-1:0] data,
    output logic                              valid,
    output logic                              tag,
    output logic                              is_tail
);

    logic signed [dqs_pkg::DATA_W-1:0] data_reg;
    logic signed [dqs_pkg::DATA_W-1:0] data_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic                              tag_reg;
    logic                              tag_next;

    // This cell holds the back entry when it is occupied and its right neighbor is not.
    assign is_tail = valid_reg && !right_valid;

    // Next contents of the cell for the operation broadcast along the chain.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        tag_next   = tag_reg;
        case (ctrl.op)
            dqs_pkg::OP_PUSH_FRONT:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            dqs_pkg::OP_PUSH_BACK:
            begin
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            dqs_pkg::OP_POP_FRONT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            dqs_pkg::OP_POP_BACK:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            dqs_pkg::OP_MARK:
            begin
                tag_next = is_tail;
            end
            dqs_pkg::OP_ROTATE:
            begin
                // The back cell takes the front entry, the other occupied cells shift toward the front.
                if (is_tail)
                begin
                    data_next = head_data;
                    tag_next  = head_tag;
                end
                else if (valid_reg)
                begin
                    data_next = right_data;
                    tag_next  = right_tag;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
                tag_next   = tag_reg;
            end
        endcase
    end

    // Occupancy and end-of-dump mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tag_reg   <= tag_next;
        end
    end

    // Stored value.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tag   = tag_reg;

endmodule

/* hw/rtl/bounded_deque_store.sv */
// Channel | Dir | Signals                                        | Contents
// s_axis  | in  | tvalid, tready, tdata[31:0], tuser[2:0]        | request: value, req_type
// m_axis  | out | tvalid, tready, tdata[31:0], tuser[1:0], tlast | result: value_res, status, last
//
// A new request is taken while the previous result waits in the output register if
// that register is drained. A dump first marks the back cell, then rotates the cell
// chain once per emitted entry; no request is taken meanwhile.
// Reset empties the chain at once; stored values are not cleared.
// A stall on m_axis holds the output register and stops the chain.
module bounded_deque_store #(
    parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [dqs_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] value
    input  logic [dqs_pkg::REQ_W-1:0]           s_axis_tuser,   // [2:0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [dqs_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] value_res
    output logic [dqs_pkg::STATUS_W-1:0]        m_axis_tuser,   // [1:0] status
    output logic                                m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    dqs_pkg::cell_ctrl_t ctrl;

    logic signed [dqs_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]                  cell_valid;
    logic [DEPTH-1:0]                  cell_tag;
    logic [DEPTH-1:0]                  cell_tail;
    logic signed [dqs_pkg::DATA_W-1:0] tail_data;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [dqs_pkg::DATA_W-1:0] out_value_reg;
    logic signed [dqs_pkg::DATA_W-1:0] out_value_next;
    logic [dqs_pkg::STATUS_W-1:0]      out_status_reg;
    logic [dqs_pkg::STATUS_W-1:0]      out_status_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic out_free;
    logic accept;
    logic empty;
    logic full;

    // Chain of cells; cell zero holds the front entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [dqs_pkg::DATA_W-1:0] left_data;
        logic                              left_valid;
        logic signed [dqs_pkg::DATA_W-1:0] right_data;
        logic                              right_valid;
        logic                              right_tag;

        if (i == 0)
        begin : g_first
            assign left_data  = ctrl.value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
            assign right_tag   = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
            assign right_tag   = cell_tag[i+1];
        end

        dqs_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .right_tag   (right_tag),
            .head_data   (cell_data[0]),
            .head_tag    (cell_tag[0]),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tag         (cell_tag[i]),
            .is_tail     (cell_tail[i])
        );
    end

    // Back entry, picked by the one-hot tail flags.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_tail[i])
            begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    assign empty         = !cell_valid[0];
    assign full          = cell_valid[DEPTH-1];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Request decode, chain control and result formation.
    always_comb
    begin
        ctrl.op         = dqs_pkg::OP_HOLD;
        ctrl.value      = s_axis_tdata;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = dqs_pkg::STAT_OK;
                    out_last_next   = 1'b1;
                    case (s_axis_tuser)
                        dqs_pkg::REQ_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_status_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op = dqs_pkg::OP_PUSH_FRONT;
                            end
                        end
                        dqs_pkg::REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_status_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op = dqs_pkg::OP_PUSH_BACK;
                            end
                        end
                        dqs_pkg::REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_status_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.op        = dqs_pkg::OP_POP_FRONT;
                                out_value_next = cell_data[0];
                            end
                        end
                        dqs_pkg::REQ_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_status_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.op        = dqs_pkg::OP_POP_BACK;
                                out_value_next = tail_data;
                            end
                        end
                        dqs_pkg::REQ_DUMP:
                        begin
                            if (empty)
                            begin
                                out_status_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // Mark the back cell; entries follow from the next cycle.
                                ctrl.op        = dqs_pkg::OP_MARK;
                                out_valid_next = 1'b0;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                // Emit the front entry and rotate the chain by one.
                if (out_free)
                begin
                    ctrl.op         = dqs_pkg::OP_ROTATE;
                    out_valid_next  = 1'b1;
                    out_value_next  = cell_data[0];
                    out_status_next = dqs_pkg::STAT_OK;
                    out_last_next   = cell_tag[0];
                    if (cell_tag[0])
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Occupied cells always form an unbroken run from the front.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + DEPTH'(1))) == '0)
        else $error("occupied cells are not contiguous from the front");

    // A dump in progress never runs on an empty chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> !empty)
        else $error("dump in progress with an empty chain");

    // Empty and full reports carry a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != dqs_pkg::STAT_OK) |-> (m_axis_tdata == '0))
        else $error("non-ok result carries a value");

    // Exactly one cell is marked as the back of the list while a dump runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> $onehot(cell_tag & cell_valid))
        else $error("dump end mark lost or duplicated");
`endif

endmodule

/* test/bounded_deque_store_test.sv */
module bounded_deque_store_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = dqs_pkg::DEPTH_DEF;
    localparam int MAX_GAP        = 17;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int RANDOM_ITEMS   = 260;
    localparam int PHASE_LEN      = 40;

    // Request codes that the block must ignore.
    localparam logic [dqs_pkg::REQ_W-1:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [dqs_pkg::REQ_W-1:0] REQ_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [dqs_pkg::STATUS_W-1:0]       status;
        logic signed [dqs_pkg::DATA_W-1:0]  value;
        logic                               last;
    } deque_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic signed [dqs_pkg::DATA_W-1:0]    s_axis_tdata;
    logic [dqs_pkg::REQ_W-1:0]            s_axis_tuser;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic signed [dqs_pkg::DATA_W-1:0]    m_axis_tdata;
    logic [dqs_pkg::STATUS_W-1:0]         m_axis_tuser;
    logic                                 m_axis_tlast;

    // Predicted deque contents and the results still owed by the block.
    logic signed [dqs_pkg::DATA_W-1:0]    model_slots [DEPTH];
    int                                   model_head;
    int                                   model_count;
    deque_result_t                        expected_results [$];

    int                                   error_count;
    bit                                   tx_idle_on;
    bit                                   rx_idle_on;
    int                                   rx_wait_left;
    int                                   rx_hold_left;

    bounded_deque_store #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void expect_result(logic [dqs_pkg::STATUS_W-1:0] status,
                                          logic signed [dqs_pkg::DATA_W-1:0] value,
                                          logic last);
        deque_result_t r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted request to the predicted deque and queue its results.
    function automatic void predict_deque_results(logic [dqs_pkg::REQ_W-1:0] req,
                                                  logic signed [dqs_pkg::DATA_W-1:0] value);
        int slot;
        case (req)
            dqs_pkg::REQ_PUSH_FRONT, dqs_pkg::REQ_PUSH_BACK:
            begin
                if (model_count >= DEPTH)
                begin
                    expect_result(dqs_pkg::STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (req == dqs_pkg::REQ_PUSH_FRONT)
                    begin
                        model_head = (model_head + DEPTH - 1) % DEPTH;
                        slot = model_head;
                    end
                    else
                    begin
                        slot = (model_head + model_count) % DEPTH;
                    end
                    model_slots[slot] = value;
                    model_count++;
                    expect_result(dqs_pkg::STAT_OK, '0, 1'b1);
                end
            end
            dqs_pkg::REQ_POP_FRONT:
            begin
                if (model_count == 0)
                begin
                    expect_result(dqs_pkg::STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    expect_result(dqs_pkg::STAT_OK, model_slots[model_head], 1'b1);
                    model_head = (model_head + 1) % DEPTH;
                    model_count--;
                end
            end
            dqs_pkg::REQ_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    expect_result(dqs_pkg::STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    expect_result(dqs_pkg::STAT_OK,
                                  model_slots[(model_head + model_count - 1) % DEPTH], 1'b1);
                    model_count--;
                end
            end
            dqs_pkg::REQ_DUMP:
            begin
                if (model_count == 0)
                begin
                    expect_result(dqs_pkg::STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < model_count; i++)
                    begin
                        expect_result(dqs_pkg::STAT_OK, model_slots[(model_head + i) % DEPTH],
                                      i == model_count - 1);
                    end
                end
            end
            default:
            begin
                // Reserved codes leave the deque untouched and produce nothing.
            end
        endcase
    endfunction

    // Extreme values show up often; the rest are uniform.
    function automatic logic signed [dqs_pkg::DATA_W-1:0] random_value();
        logic signed [dqs_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = '0;
            3:       v = -32'sd1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one request, after a random gap when tx_idle_on is set, and hold it until accepted.
    task automatic send_request(input logic [dqs_pkg::REQ_W-1:0] req,
                                input logic signed [dqs_pkg::DATA_W-1:0] value);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_deque_results(req, value);
    endtask

    task automatic sender_release();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty reports, reserved codes, extreme values and the head kept after emptying.
    task automatic test_empty_and_extremes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_request(dqs_pkg::REQ_POP_FRONT, 32'sd17);
        send_request(dqs_pkg::REQ_POP_BACK, -32'sd17);
        send_request(dqs_pkg::REQ_DUMP, 32'sd5);
        for (int code = int'(REQ_RESERVED_FIRST); code <= int'(REQ_RESERVED_LAST); code++)
            send_request(code[dqs_pkg::REQ_W-1:0], $urandom);
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'sh8000_0000);
        send_request(dqs_pkg::REQ_PUSH_FRONT, '0);
        send_request(dqs_pkg::REQ_PUSH_BACK, -32'sd1);
        send_request(dqs_pkg::REQ_DUMP, '0);
        send_request(dqs_pkg::REQ_POP_BACK, '0);
        send_request(dqs_pkg::REQ_POP_FRONT, '0);
        send_request(dqs_pkg::REQ_POP_BACK, '0);
        send_request(dqs_pkg::REQ_POP_FRONT, '0);
        send_request(dqs_pkg::REQ_POP_FRONT, '0);
        // The head pointer stays where it was when the deque ran empty.
        send_request(dqs_pkg::REQ_PUSH_BACK, 32'sh5A5A_5A5A);
        send_request(dqs_pkg::REQ_PUSH_FRONT, 32'shA5A5_A5A5);
        send_request(dqs_pkg::REQ_DUMP, '0);
        send_request(dqs_pkg::REQ_POP_FRONT, '0);
        send_request(dqs_pkg::REQ_POP_FRONT, '0);
        send_request(dqs_pkg::REQ_DUMP, '0);
    endtask

    // Fill to capacity from both ends, report full, dump all, then drain.
    task automatic test_full_store();
        for (int i = 0; i < DEPTH; i++)
            send_request($urandom_range(0, 1) ? dqs_pkg::REQ_PUSH_FRONT : dqs_pkg::REQ_PUSH_BACK,
                         random_value());
        send_request(dqs_pkg::REQ_PUSH_FRONT, random_value());
        send_request(dqs_pkg::REQ_PUSH_BACK, random_value());
        send_request(dqs_pkg::REQ_DUMP, '0);
        while (model_count > 0)
            send_request($urandom_range(0, 1) ? dqs_pkg::REQ_POP_FRONT : dqs_pkg::REQ_POP_BACK,
                         '0);
        send_request(dqs_pkg::REQ_POP_BACK, '0);
        send_request(dqs_pkg::REQ_DUMP, '0);
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_hold_left = HOLD_OFF_LEN;
        for (int i = 0; i < 24; i++)
            send_request(dqs_pkg::REQ_PUSH_BACK, random_value());
        send_request(dqs_pkg::REQ_DUMP, '0);
        rx_hold_left = HOLD_OFF_LEN;
        for (int i = 0; i < 8; i++)
            send_request(dqs_pkg::REQ_POP_FRONT, '0);
        send_request(dqs_pkg::REQ_DUMP, '0);
        tx_idle_on = 1'b1;
    endtask

    // The sender goes quiet until every owed result has been taken.
    task automatic test_pause_until_drained();
        send_request(dqs_pkg::REQ_DUMP, '0);
        send_request(dqs_pkg::REQ_PUSH_FRONT, random_value());
        sender_release();
        wait_for_results();
        send_request(dqs_pkg::REQ_POP_BACK, '0);
        send_request(dqs_pkg::REQ_DUMP, '0);
        sender_release();
        wait_for_results();
    endtask

    // Mostly push and pop steered toward a changing fill target, with dumps and noise.
    task automatic test_random_traffic();
        int                          sent;
        int                          target;
        int                          roll;
        int                          code;
        bit                          grow;
        logic [dqs_pkg::REQ_W-1:0]   req;
        sent = 0;
        target = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       target = 0;
                    1:       target = DEPTH;
                    2:       target = $urandom_range(1, 8);
                    default: target = $urandom_range(0, DEPTH);
                endcase
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                code = $urandom_range(int'(REQ_RESERVED_FIRST), int'(REQ_RESERVED_LAST));
                req  = code[dqs_pkg::REQ_W-1:0];
            end
            else if (roll < 12)
            begin
                req = dqs_pkg::REQ_DUMP;
            end
            else
            begin
                if (model_count < target)
                    grow = ($urandom_range(0, 3) != 0);
                else if (model_count > target)
                    grow = ($urandom_range(0, 3) == 0);
                else
                    grow = ($urandom_range(0, 1) != 0);
                if (grow)
                    req = $urandom_range(0, 1) ? dqs_pkg::REQ_PUSH_FRONT
                                               : dqs_pkg::REQ_PUSH_BACK;
                else
                    req = $urandom_range(0, 1) ? dqs_pkg::REQ_POP_FRONT
                                               : dqs_pkg::REQ_POP_BACK;
            end
            send_request(req, random_value());
            if (req <= dqs_pkg::REQ_DUMP)
                sent++;
        end
    endtask

    // Receiver: a long hold-off first, otherwise the per-result random stall.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait_left > 0)
            begin
                rx_wait_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest owed one.
    initial
    begin
        deque_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                rx_wait_left = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d value %0d",
                             $time, m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stop a hung run when no request or result moves for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL bounded_deque_store");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dqs_pkg::REQ_PUSH_FRONT;
        model_head    = 0;
        model_count   = 0;
        error_count   = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_wait_left  = 0;
        rx_hold_left  = 0;
        for (int i = 0; i < DEPTH; i++)
            model_slots[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_extremes();
        test_full_store();
        test_output_backpressure();
        test_pause_until_drained();
        test_random_traffic();

        sender_release();
        wait_for_results();
        repeat (DEPTH + 16) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS bounded_deque_store");
        else
            $display("FAIL bounded_deque_store");
        $finish;
    end

endmodule
